[hw/rtl/lkvc_pkg.sv]
// Package for the LRU key/value cache with expiry: beat structs, cell command
// types, FSM states and key/length masking helpers. No dependencies.
package lkvc_pkg;

    localparam int ENTRIES     = 16;
    localparam int RANK_W      = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_INVAL  = 3'd2;
    localparam logic [2:0] OP_PREFIX = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] key_bytes;
        logic [3:0]  prefix_length;
        logic [63:0] data_in;
        logic [7:0]  data_length;
        logic [15:0] lifetime;
        logic [7:0]  read_limit;
        logic [31:0] now;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic [63:0] data_out;
        logic [3:0]  returned_length;
        logic [4:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_out_beat;

    typedef enum logic [1:0] {SEL_MATCH, SEL_PREFIX, SEL_FREE, SEL_LRU} t_sel;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_HIT, ACT_DROP, ACT_AGE, ACT_WRITE, ACT_CLEAR
    } t_act;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SCAN, ST_ACT, ST_AGE, ST_WRITE,
        ST_EVICT0, ST_DROP0, ST_CLEAR, ST_DONE
    } t_state;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              start;
        logic              scan;
        logic              go;
        t_sel              sel;
        t_act              act;
        logic [RANK_W-1:0] ref_rank;
        logic [63:0]       key;
        logic [63:0]       pmask;
        logic [63:0]       value;
        logic [3:0]        len;
        logic [32:0]       expiry;
    } t_cmd;

    // per-cell report; slot fields are zero unless the cell holds the token
    typedef struct packed {
        logic              tok;
        logic              claim;
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [63:0]       value;
        logic [3:0]        len;
        logic [32:0]       expiry;
    } t_cell_out;

    // token holder summary seen by the sequencer
    typedef struct packed {
        logic              claim_any;
        logic              tok_any;
        logic [RANK_W-1:0] rank;
        logic [63:0]       value;
        logic [3:0]        len;
        logic [32:0]       expiry;
    } t_hold;

    function automatic logic [63:0] byte_mask(logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[8*i +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // keep bytes up to the first NUL, at most lim bytes
    function automatic logic [63:0] cut_at_nul(logic [63:0] k, logic [3:0] lim);
        logic        alive;
        logic [63:0] m;
        alive = 1'b1;
        m     = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= lim || k[8*i +: 8] == 8'h00) alive = 1'b0;
            if (alive) m[8*i +: 8] = 8'hFF;
        end
        return k & m;
    endfunction

endpackage

[hw/rtl/lkvc_cell.sv]
// One cache slot of the cell row: key, value, length, expiry and LRU rank,
// plus the scan token passed to the next cell. Depends on lkvc_pkg.
module lkvc_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lkvc_pkg::t_cmd           i_cmd,
    input  logic [lkvc_pkg::CNT_W-1:0] i_count,
    input  logic                     i_tok,
    output logic                     o_pass,
    output lkvc_pkg::t_cell_out      o_cell
);
    import lkvc_pkg::*;

    logic              r_valid, n_valid;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              r_tok, n_tok;
    logic [63:0]       r_key, n_key;
    logic [63:0]       r_value, n_value;
    logic [3:0]        r_len, n_len;
    logic [32:0]       r_exp, n_exp;
    logic              cond;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_MATCH:  cond = r_valid && (r_key == i_cmd.key);
            SEL_PREFIX: cond = r_valid && (((r_key ^ i_cmd.key) & i_cmd.pmask) == '0);
            SEL_FREE:   cond = !r_valid;
            SEL_LRU:    cond = r_valid &&
                               ((CNT_W'({1'b0, r_rank}) + CNT_W'(1)) == i_count);
        endcase
    end

    assign o_pass = r_tok && ((i_cmd.scan && !cond) || i_cmd.go);

    always_comb begin
        n_tok   = i_tok | (r_tok & !o_pass & !i_cmd.start);
        n_valid = r_valid;
        n_rank  = r_rank;
        n_key   = r_key;
        n_value = r_value;
        n_len   = r_len;
        n_exp   = r_exp;
        unique case (i_cmd.act)
            ACT_NONE: ;
            ACT_HIT: begin
                if (r_tok) n_rank = '0;
                else if (r_valid && r_rank < i_cmd.ref_rank) n_rank = r_rank + 1'b1;
            end
            ACT_DROP: begin
                if (r_tok) begin
                    n_valid = 1'b0;
                    n_rank  = '0;
                end else if (r_valid && r_rank > i_cmd.ref_rank) begin
                    n_rank = r_rank - 1'b1;
                end
            end
            ACT_AGE: begin
                if (r_valid) n_rank = r_rank + 1'b1;
            end
            ACT_WRITE: begin
                if (r_tok) begin
                    n_valid = 1'b1;
                    n_rank  = '0;
                    n_key   = i_cmd.key;
                    n_value = i_cmd.value;
                    n_len   = i_cmd.len;
                    n_exp   = i_cmd.expiry;
                end
            end
            ACT_CLEAR: begin
                n_valid = 1'b0;
                n_rank  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_tok   <= n_tok;
        end
        r_key   <= n_key;
        r_value <= n_value;
        r_len   <= n_len;
        r_exp   <= n_exp;
    end

    always_comb begin
        o_cell.tok    = r_tok;
        o_cell.claim  = r_tok && cond;
        o_cell.valid  = r_valid;
        o_cell.rank   = r_tok ? r_rank  : '0;
        o_cell.value  = r_tok ? r_value : '0;
        o_cell.len    = r_tok ? r_len   : '0;
        o_cell.expiry = r_tok ? r_exp   : '0;
    end

endmodule

[hw/rtl/lkvc_ctrl.sv]
// Operation sequencer: input and output beat registers, scan/act FSM,
// entry count and saturating hit/miss counters. Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lkvc_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lkvc_pkg::t_out_beat        o_out_data,
    input  lkvc_pkg::t_hold            i_hold,
    output lkvc_pkg::t_cmd             o_cmd,
    output logic [lkvc_pkg::CNT_W-1:0] o_count
);
    import lkvc_pkg::*;

    t_state          r_state, n_state;
    t_sel            r_sel, n_sel;
    logic [2:0]      r_op;
    logic [63:0]     r_key, r_pre, r_pmask, r_value;
    logic [3:0]      r_len;
    logic [32:0]     r_exp;
    logic [7:0]      r_rlim;
    logic [31:0]     r_now;
    logic            r_new;
    logic [CNT_W-1:0] r_count;
    logic [31:0]     r_hits, r_misses;
    logic            r_hit;
    logic [63:0]     r_dout;
    logic [3:0]      r_rlen;
    logic            r_ovalid;
    t_out_beat       r_obeat;

    logic            accept, expired;
    logic [3:0]      get_n, dlen_sat, plen_sat;
    logic            f_dec, f_inc, f_hit, f_miss, f_new, f_old, f_load_out;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_obeat;
    assign o_count     = r_count;

    assign dlen_sat = (i_in_data.data_length > 8'(VALUE_BYTES)) ?
                      4'(VALUE_BYTES) : i_in_data.data_length[3:0];
    assign plen_sat = (i_in_data.prefix_length > 4'd8) ? 4'd8 : i_in_data.prefix_length;
    assign expired  = (i_hold.expiry != '0) && ({1'b0, r_now} > i_hold.expiry);
    assign get_n    = ({4'b0, i_hold.len} <= r_rlim) ? i_hold.len : r_rlim[3:0];

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_in_data.opcode)
                        OP_GET, OP_PUT, OP_INVAL: begin
                            n_state = ST_LOAD;
                            n_sel   = SEL_MATCH;
                        end
                        OP_PREFIX: begin
                            n_state = ST_LOAD;
                            n_sel   = SEL_PREFIX;
                        end
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_hold.claim_any) begin
                    n_state = ST_ACT;
                end else if (!i_hold.tok_any) begin
                    if (r_op == OP_PUT && r_sel == SEL_MATCH) begin
                        n_state = ST_LOAD;
                        n_sel   = SEL_FREE;
                    end else if (r_op == OP_PUT && r_sel == SEL_FREE) begin
                        n_state = ST_LOAD;
                        n_sel   = SEL_LRU;
                    end else if (r_op == OP_PUT) begin
                        n_state = ST_EVICT0;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ACT: begin
                if (r_op == OP_PUT) begin
                    n_state = (r_sel == SEL_LRU) ? ST_AGE : ST_WRITE;
                end else if (r_op == OP_PREFIX) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EVICT0: n_state = ST_DROP0;
            ST_DROP0:  n_state = ST_AGE;
            ST_AGE:    n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_DONE;
            ST_CLEAR:  n_state = ST_DONE;
            ST_DONE: begin
                if (!r_ovalid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cell commands and bookkeeping strobes
    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = r_sel;
        o_cmd.act      = ACT_NONE;
        o_cmd.ref_rank = i_hold.rank;
        o_cmd.key      = (r_sel == SEL_PREFIX) ? r_pre : r_key;
        o_cmd.pmask    = r_pmask;
        o_cmd.value    = r_value;
        o_cmd.len      = r_len;
        o_cmd.expiry   = r_exp;
        f_dec      = 1'b0;
        f_inc      = 1'b0;
        f_hit      = 1'b0;
        f_miss     = 1'b0;
        f_new      = 1'b0;
        f_old      = 1'b0;
        f_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_LOAD:   o_cmd.start = 1'b1;
            ST_EVICT0: o_cmd.start = 1'b1;
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (!i_hold.claim_any && !i_hold.tok_any && r_op == OP_GET) f_miss = 1'b1;
            end
            ST_ACT: begin
                if (r_op == OP_GET) begin
                    if (expired) begin
                        o_cmd.act = ACT_DROP;
                        f_dec     = 1'b1;
                        f_miss    = 1'b1;
                    end else begin
                        o_cmd.act = ACT_HIT;
                        f_hit     = 1'b1;
                    end
                end else if (r_op == OP_PUT) begin
                    if (r_sel == SEL_MATCH) begin
                        o_cmd.act = ACT_HIT;
                        f_old     = 1'b1;
                    end else if (r_sel == SEL_FREE) begin
                        o_cmd.act = ACT_AGE;
                        f_new     = 1'b1;
                    end else begin
                        o_cmd.act = ACT_DROP;
                        f_dec     = 1'b1;
                        f_new     = 1'b1;
                    end
                end else begin
                    o_cmd.act = ACT_DROP;
                    f_dec     = 1'b1;
                    o_cmd.go  = (r_op == OP_PREFIX);
                end
            end
            ST_DROP0: begin
                o_cmd.act = ACT_DROP;
                f_dec     = 1'b1;
                f_new     = 1'b1;
            end
            ST_AGE: o_cmd.act = ACT_AGE;
            ST_WRITE: begin
                o_cmd.act = ACT_WRITE;
                f_inc     = r_new;
            end
            ST_CLEAR: o_cmd.act = ACT_CLEAR;
            ST_DONE:  f_load_out = !r_ovalid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sel    <= SEL_MATCH;
            r_count  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_ovalid <= 1'b0;
            r_new    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (r_state == ST_CLEAR) r_count <= '0;
            else if (f_dec && r_count != '0) r_count <= r_count - 1'b1;
            else if (f_inc) r_count <= r_count + 1'b1;
            if (f_hit && r_hits != '1) r_hits <= r_hits + 1'b1;
            if (f_miss && r_misses != '1) r_misses <= r_misses + 1'b1;
            if (f_new) r_new <= 1'b1;
            else if (f_old || accept) r_new <= 1'b0;
            if (f_load_out) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in_data.opcode;
            r_key   <= cut_at_nul(i_in_data.key_bytes, 4'(KEY_BYTES));
            r_pre   <= cut_at_nul(i_in_data.key_bytes, 4'd8);
            r_pmask <= byte_mask(plen_sat);
            r_value <= i_in_data.data_in & byte_mask(dlen_sat);
            r_len   <= dlen_sat;
            r_exp   <= (i_in_data.lifetime != '0) ?
                       ({1'b0, i_in_data.now} + 33'(i_in_data.lifetime)) : '0;
            r_rlim  <= i_in_data.read_limit;
            r_now   <= i_in_data.now;
            r_hit   <= 1'b0;
            r_dout  <= '0;
            r_rlen  <= '0;
        end else if (f_hit) begin
            r_hit  <= 1'b1;
            r_dout <= i_hold.value & byte_mask(get_n);
            r_rlen <= get_n;
        end
        if (f_load_out) begin
            r_obeat.hit             <= r_hit;
            r_obeat.data_out        <= r_dout;
            r_obeat.returned_length <= r_rlen;
            r_obeat.entry_count     <= 5'(r_count);
            r_obeat.hit_total       <= r_hits;
            r_obeat.miss_total      <= r_misses;
        end
    end

endmodule

[hw/rtl/lru_key_value_cache_ttl_top.sv]
// Usage: fully associative 16-entry key/value cache with LRU replacement
// and per-entry expiry (get, put, invalidate, invalidate-by-prefix, clear).
// Input channel: i_in_valid / o_in_stall carry one t_in_beat per operation;
// a beat is taken when valid is high and stall low. Output channel:
// o_out_valid / i_out_stall return one t_out_beat per operation, in order.
// One operation is in flight at a time. A scan token walks the row of slot
// cells one cell per cycle until a cell claims it. Clear and unused opcodes
// skip the scan; get and invalidate use one scan, as does put on a present
// key; a put into a free slot uses a match scan, then a free scan; a put
// that evicts uses three scans; invalidate-by-prefix adds one drop step per
// dropped entry. The next beat is taken in ST_IDLE, which follows ST_DONE,
// where the result is loaded. The result sits in an output register, so the
// next operation is taken while the receiver stalls the previous result;
// a finished operation waits only if that register is still occupied.
// Reset (synchronous, active low) empties all slots, zeroes the entry count
// and both counters; no clearing sweep is needed.
// Depends on lkvc_pkg, lkvc_cell and lkvc_ctrl.
module lru_key_value_cache_ttl_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lkvc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lkvc_pkg::t_out_beat o_out_data
);
    import lkvc_pkg::*;

    t_cmd             cmd;
    t_hold            hold;
    logic [CNT_W-1:0] count;
    t_cell_out        cells [ENTRIES];
    logic [ENTRIES:0] tok_chain;     // token hand-off between neighbors
    logic [ENTRIES-1:0] tok_vec, valid_vec;

    assign tok_chain[0] = cmd.start;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_count (count),
            .i_tok   (tok_chain[g]),
            .o_pass  (tok_chain[g+1]),
            .o_cell  (cells[g])
        );
        assign tok_vec[g]   = cells[g].tok;
        assign valid_vec[g] = cells[g].valid;
    end

    // holder fields are zero outside the token cell, so OR picks the holder
    always_comb begin
        hold = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hold.claim_any = hold.claim_any | cells[i].claim;
            hold.tok_any   = hold.tok_any   | cells[i].tok;
            hold.rank      = hold.rank      | cells[i].rank;
            hold.value     = hold.value     | cells[i].value;
            hold.len       = hold.len       | cells[i].len;
            hold.expiry    = hold.expiry    | cells[i].expiry;
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_hold      (hold),
        .o_cmd       (cmd),
        .o_count     (count)
    );

`ifndef SYNTH
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan token in the cell row");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(count) == 32'($countones(valid_vec)))
        else $error("entry count disagrees with valid slots");

    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |-> o_out_data.entry_count != '0)
        else $error("hit reported with empty cache");
`endif

endmodule
